/* rtl/ipv6_next_header_locator_defines.svh */
// Assertion macros shared by the next-header locator RTL.
`ifndef IPV6_NEXT_HEADER_LOCATOR_DEFINES_SVH
`define IPV6_NEXT_HEADER_LOCATOR_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define NHL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define NHL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ipv6nhl_pkg.sv */
// Package: constants, types and helpers of the IPv6 next-header locator.
package ipv6nhl_pkg;

  localparam int OFFSET_BITS_DEF = 16;

  localparam int BASE_END    = 40;  // first byte after the base header
  localparam int BASE_NH_POS = 6;   // next-header byte of the base header

  localparam logic [7:0] NH_HOP  = 8'd0;
  localparam logic [7:0] NH_ROUT = 8'd43;
  localparam logic [7:0] NH_FRAG = 8'd44;
  localparam logic [7:0] NH_AUTH = 8'd51;
  localparam logic [7:0] NH_DEST = 8'd60;

  localparam logic [11:0] FRAG_LEN = 12'd8;

  // mode_flags bit positions
  localparam int MF_SET_PROTO = 0;
  localparam int MF_STOP_FRAG = 1;
  localparam int MF_STOP_AUTH = 2;

  localparam int MODE_BITS = 3;
  localparam int CFG_DATA_BITS = 8;

  typedef enum logic {
    REG_MODE_FLAGS   = 1'b0,
    REG_NEW_PROTOCOL = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_BASE,
    PH_NEXT,
    PH_LEN,
    PH_FOFS_HI,
    PH_FOFS_LO,
    PH_DONE,
    PH_OVER
  } walk_phase_t;

  function automatic logic is_ext(input logic [7:0] v);
    return (v == NH_HOP) || (v == NH_ROUT) || (v == NH_FRAG) ||
           (v == NH_AUTH) || (v == NH_DEST);
  endfunction

  // (len + 1) * 8
  function automatic logic [11:0] ext_len(input logic [7:0] len);
    logic [8:0] units;
    units = {1'b0, len} + 9'd1;
    return {units, 3'b000};
  endfunction

  // (len + 2) * 4
  function automatic logic [11:0] auth_len(input logic [7:0] len);
    logic [8:0] units;
    units = {1'b0, len} + 9'd2;
    return {1'b0, units, 2'b00};
  endfunction

endpackage

/* rtl/ipv6_next_header_locator.sv */
// Top level: IPv6 extension header chain walker giving one verdict per packet.
// Usage:
//   Input stream: one packet byte per transaction on in_tdata[7:0], in_tlast
//   high on the final byte. Bytes are tracked by a running offset from the
//   first byte; the walk starts at the base header's next-header byte (offset 6)
//   and hops across hop-by-hop, routing, fragment, auth and destination headers.
//   Output stream: one transaction per packet, issued after the last byte;
//   it carries drop (truncated / offset overflow), rewrite_valid and the
//   offset of the next-header byte a downstream editor should overwrite.
//   Config: cfg_wr_en writes mode_flags (index 0) or new_protocol (index 1);
//   write only between packets. The protocol byte itself is applied by the
//   downstream editor, so only mode_flags is kept here.
// Timing:
//   One byte per cycle, back to back, while in_tready is high. Each byte costs
//   one compare against the current header offset plus one length add.
//   Verdict is registered: out_tvalid rises the cycle after the last byte.
// Reset / stall:
//   Synchronous reset clears the walk state and out_tvalid, not the verdict payload.
//   While a verdict waits for out_tready, in_tready stays high only if the
//   verdict is taken in the same cycle; otherwise input is held off.
module ipv6_next_header_locator
  import ipv6nhl_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input stream
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,   // [7:0] pkt_byte
  input  logic                     in_tlast,   // last_byte
  // verdict stream
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [23:0]              out_tdata,  // [0] verdict_drop, [1] rewrite_valid,
                                               // [17:2] rewrite_offset, [23:18] zero
  // config write port
  input  logic                     cfg_wr_en,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int W  = OFFSET_BITS;
  localparam int NW = ((W > 12) ? W : 12) + 1;  // header_start + length, with carry
  localparam logic [W-1:0] OFS_MASK = {W{1'b1}};

  // walk state
  logic [W-1:0]           byte_count_r,   byte_count_nxt;
  logic                   count_full_r,   count_full_nxt;
  logic [W-1:0]           header_start_r, header_start_nxt;
  logic [7:0]             followed_r,     followed_nxt;
  logic [W-1:0]           target_r,       target_nxt;
  logic [7:0]             frag_nv_r,      frag_nv_nxt;
  logic [7:0]             fofs_hi_r,      fofs_hi_nxt;
  walk_phase_t            phase_r,        phase_nxt;
  logic                   skip_r,         skip_nxt;
  logic [MODE_BITS-1:0]   mode_r,         mode_nxt;

  // verdict register
  logic                   out_valid_r,    out_valid_nxt;
  logic                   drop_r,         drop_nxt;
  logic                   rv_r,           rv_nxt;
  logic [15:0]            ofs_r,          ofs_nxt;

  logic                   in_acc;
  logic [7:0]             b;
  logic                   at0, at1, at2, at3;
  logic                   adv_en;
  logic [11:0]            adv_len;
  logic [NW-1:0]          adv_sum;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign b          = in_tdata;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, ofs_r, rv_r, drop_r};

  // position compares, one bit wider so a sum past the top never aliases
  assign at0 = (byte_count_r == header_start_r);
  assign at1 = ({1'b0, byte_count_r} == ({1'b0, header_start_r} + (W+1)'(1)));
  assign at2 = ({1'b0, byte_count_r} == ({1'b0, header_start_r} + (W+1)'(2)));
  assign at3 = ({1'b0, byte_count_r} == ({1'b0, header_start_r} + (W+1)'(3)));

  assign adv_sum = NW'(header_start_r) + NW'(adv_len);

  // config
  always_comb begin
    mode_nxt = mode_r;
    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE_FLAGS:   mode_nxt = cfg_wdata[MODE_BITS-1:0];
        REG_NEW_PROTOCOL: mode_nxt = mode_r;  // held by the downstream editor
        default:          mode_nxt = mode_r;
      endcase
    end
  end

  // walk and verdict
  always_comb begin
    byte_count_nxt   = byte_count_r;
    count_full_nxt   = count_full_r;
    header_start_nxt = header_start_r;
    followed_nxt     = followed_r;
    target_nxt       = target_r;
    frag_nv_nxt      = frag_nv_r;
    fofs_hi_nxt      = fofs_hi_r;
    phase_nxt        = phase_r;
    skip_nxt         = skip_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    drop_nxt         = drop_r;
    rv_nxt           = rv_r;
    ofs_nxt          = ofs_r;
    adv_en           = 1'b0;
    adv_len          = '0;

    if (in_acc) begin
      if (count_full_r) begin
        if (phase_r != PH_DONE) phase_nxt = PH_OVER;
      end else begin
        case (phase_r)
          PH_BASE: begin
            if (byte_count_r == W'(BASE_NH_POS)) begin
              followed_nxt = b;
              phase_nxt    = is_ext(b) ? PH_NEXT : PH_DONE;
            end
          end
          PH_NEXT: begin
            if (at0) begin
              frag_nv_nxt = b;
              phase_nxt   = PH_LEN;
            end
          end
          PH_LEN: begin
            if (at1) begin
              if (followed_r == NH_FRAG) begin
                phase_nxt = mode_r[MF_STOP_FRAG] ? PH_DONE : PH_FOFS_HI;
              end else if (followed_r == NH_AUTH) begin
                if (mode_r[MF_STOP_AUTH]) begin
                  phase_nxt = PH_DONE;
                end else begin
                  adv_en  = 1'b1;
                  adv_len = auth_len(b);
                end
              end else begin
                adv_en  = 1'b1;
                adv_len = ext_len(b);
              end
            end
          end
          PH_FOFS_HI: begin
            if (at2) begin
              fofs_hi_nxt = b;
              phase_nxt   = PH_FOFS_LO;
            end
          end
          PH_FOFS_LO: begin
            if (at3) begin
              if ({fofs_hi_r, b[7:3]} != 13'd0) begin
                // non-first fragment: rewrite here only if the chain ends here
                if (!is_ext(frag_nv_r) || (mode_r[MF_STOP_AUTH] && frag_nv_r == NH_AUTH))
                  target_nxt = header_start_r;
                else
                  skip_nxt = 1'b1;
                phase_nxt = PH_DONE;
              end else begin
                adv_en  = 1'b1;
                adv_len = FRAG_LEN;
              end
            end
          end
          default: ;
        endcase

        if (byte_count_r == OFS_MASK) count_full_nxt = 1'b1;
        else                          byte_count_nxt = byte_count_r + 1'b1;
      end

      // step past the current header
      if (adv_en) begin
        target_nxt   = header_start_r;
        followed_nxt = frag_nv_r;
        if (!is_ext(frag_nv_r)) begin
          phase_nxt = PH_DONE;
        end else if (adv_sum[NW-1:W] != '0) begin
          phase_nxt = PH_OVER;
        end else begin
          header_start_nxt = adv_sum[W-1:0];
          phase_nxt        = PH_NEXT;
        end
      end

      if (in_tlast) begin
        out_valid_nxt = 1'b1;
        drop_nxt      = (phase_nxt != PH_DONE);
        rv_nxt        = (phase_nxt == PH_DONE) && mode_r[MF_SET_PROTO] && !skip_nxt;
        ofs_nxt       = rv_nxt ? 16'(target_nxt) : 16'd0;
        // back to the start of a packet
        byte_count_nxt   = '0;
        count_full_nxt   = 1'b0;
        header_start_nxt = W'(BASE_END);
        followed_nxt     = '0;
        target_nxt       = W'(BASE_NH_POS);
        frag_nv_nxt      = '0;
        fofs_hi_nxt      = '0;
        phase_nxt        = PH_BASE;
        skip_nxt         = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r   <= '0;
      count_full_r   <= 1'b0;
      header_start_r <= W'(BASE_END);
      followed_r     <= '0;
      target_r       <= W'(BASE_NH_POS);
      frag_nv_r      <= '0;
      fofs_hi_r      <= '0;
      phase_r        <= PH_BASE;
      skip_r         <= 1'b0;
      mode_r         <= MODE_BITS'(1);
      out_valid_r    <= 1'b0;
    end else begin
      byte_count_r   <= byte_count_nxt;
      count_full_r   <= count_full_nxt;
      header_start_r <= header_start_nxt;
      followed_r     <= followed_nxt;
      target_r       <= target_nxt;
      frag_nv_r      <= frag_nv_nxt;
      fofs_hi_r      <= fofs_hi_nxt;
      phase_r        <= phase_nxt;
      skip_r         <= skip_nxt;
      mode_r         <= mode_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // verdict payload, no reset needed
  always_ff @(posedge clk) begin
    drop_r <= drop_nxt;
    rv_r   <= rv_nxt;
    ofs_r  <= ofs_nxt;
  end

  `include "ipv6_next_header_locator_defines.svh"

  `NHL_ASSERT_NOW(a_drop_no_rewrite, out_valid_r, !(drop_r && rv_r), "drop with rewrite")
  `NHL_ASSERT_NOW(a_ofs_zero, out_valid_r && !rv_r, ofs_r == 16'd0, "offset set without rewrite")
  `NHL_ASSERT_NEXT(a_pkt_restart, in_acc && in_tlast,
                   byte_count_r == '0 && phase_r == PH_BASE, "walk not reset after last byte")
  `NHL_ASSERT_NOW(a_count_sat, count_full_r, byte_count_r == OFS_MASK, "count_full off the top")
  `NHL_ASSERT_NOW(a_next_ahead, phase_r == PH_NEXT, byte_count_r <= header_start_r,
                  "next header start already passed")

endmodule

/* verif/ipv6_next_header_locator_checker.sv */
// Checker: predicts the per-packet verdict of the next-header locator and compares it.
module ipv6_next_header_locator_checker
  import ipv6nhl_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  input  logic                     in_tready,
  input  logic [7:0]               in_tdata,
  input  logic                     in_tlast,
  input  logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic [23:0]              out_tdata,
  input  logic                     cfg_wr_en,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output int                       mismatch_count,
  output int                       verdicts_owed,
  output int                       verdict_count,
  output int                       drop_count,
  output int                       rewrite_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              OFS_W         = OFFSET_BITS_DEF;
  localparam logic [OFS_W-1:0] OFS_MAX      = '1;
  localparam logic [7:0]      FRAG_OFS_MASK = 8'hF8;
  localparam int              PRINT_CAP     = 40;

  typedef struct packed {
    logic        drop;
    logic        rw_valid;
    logic [15:0] rw_ofs;
  } verdict_t;

  verdict_t verdict_q[$];

  // register copies
  logic [MODE_BITS-1:0] mode_q;
  logic [7:0]           proto_q;  // held only, the rewrite happens downstream

  // walk state
  logic [OFS_W-1:0] pos;
  logic [OFS_W-1:0] hdr_base;
  logic [OFS_W-1:0] tgt_ofs;
  logic [7:0]       followed_nh;
  logic [7:0]       frag_nh;
  logic [7:0]       frag_ofs_hi;
  walk_phase_t      phase;
  logic             no_rewrite;
  logic             count_sat;

  int bad_n, seen_n, drop_n, rw_n;

  function automatic logic is_chain_hdr(input logic [7:0] v);
    case (v)
      NH_HOP, NH_ROUT, NH_FRAG, NH_AUTH, NH_DEST: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic clear_walk();
    pos         = '0;
    hdr_base    = OFS_W'(BASE_END);
    tgt_ofs     = OFS_W'(BASE_NH_POS);
    followed_nh = '0;
    frag_nh     = '0;
    frag_ofs_hi = '0;
    phase       = PH_BASE;
    no_rewrite  = 1'b0;
    count_sat   = 1'b0;
  endtask

  // step over the current header; stop if the value it carries ends the chain
  task automatic hop_past(input logic [11:0] len);
    logic [OFS_W:0] nxt;
    nxt         = hdr_base + len;
    tgt_ofs     = hdr_base;
    followed_nh = frag_nh;
    if (!is_chain_hdr(followed_nh)) begin
      phase = PH_DONE;
    end else if (nxt > OFS_MAX) begin
      phase = PH_OVER;
    end else begin
      hdr_base = nxt[OFS_W-1:0];
      phase    = PH_NEXT;
    end
  endtask

  task automatic chain_step(input logic [7:0] b);
    logic [15:0] fo;
    case (phase)
      PH_BASE: begin
        if (pos == BASE_NH_POS) begin
          followed_nh = b;
          phase = is_chain_hdr(b) ? PH_NEXT : PH_DONE;
        end
      end
      PH_NEXT: begin
        if (pos == hdr_base) begin
          frag_nh = b;
          phase   = PH_LEN;
        end
      end
      PH_LEN: begin
        if (pos == hdr_base + 1) begin
          if (followed_nh == NH_FRAG) begin
            phase = mode_q[MF_STOP_FRAG] ? PH_DONE : PH_FOFS_HI;
          end else if (followed_nh == NH_AUTH) begin
            if (mode_q[MF_STOP_AUTH]) phase = PH_DONE;
            else hop_past(({4'd0, b} + 12'd2) << 2);
          end else begin
            hop_past(({4'd0, b} + 12'd1) << 3);
          end
        end
      end
      PH_FOFS_HI: begin
        if (pos == hdr_base + 2) begin
          frag_ofs_hi = b;
          phase       = PH_FOFS_LO;
        end
      end
      PH_FOFS_LO: begin
        if (pos == hdr_base + 3) begin
          fo = {frag_ofs_hi, b & FRAG_OFS_MASK};
          if (fo != 16'd0) begin
            // later fragment: rewrite only if the chain ends right here
            if (!is_chain_hdr(frag_nh) || (mode_q[MF_STOP_AUTH] && frag_nh == NH_AUTH))
              tgt_ofs = hdr_base;
            else
              no_rewrite = 1'b1;
            phase = PH_DONE;
          end else begin
            hop_past(FRAG_LEN);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic take_byte(input logic [7:0] b, input logic last);
    verdict_t v;
    if (count_sat) begin
      if (phase != PH_DONE) phase = PH_OVER;
    end else begin
      chain_step(b);
      if (pos == OFS_MAX) count_sat = 1'b1;
      else pos = pos + 1'b1;
    end
    if (last) begin
      v = '0;
      if (phase == PH_DONE) begin
        v.rw_valid = mode_q[MF_SET_PROTO] && !no_rewrite;
        v.rw_ofs   = v.rw_valid ? 16'(tgt_ofs) : 16'd0;
      end else begin
        v.drop = 1'b1;
      end
      verdict_q.push_back(v);
      clear_walk();
    end
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      bad_n++;
      if (bad_n <= PRINT_CAP)
        $display("%0t: verdict %0d %s expected 0x%0h actual 0x%0h",
                 $time, seen_n, what, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    verdict_t want;
    if (!rst_n) begin
      mode_q  = MODE_BITS'(1);
      proto_q = 8'd0;
      clear_walk();
      verdict_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_MODE_FLAGS:   mode_q  = cfg_wdata[MODE_BITS-1:0];
          REG_NEW_PROTOCOL: proto_q = cfg_wdata;
          default: ;
        endcase
      end
      // older verdict leaves before a new last byte can queue one
      if (out_tvalid && out_tready) begin
        seen_n++;
        drop_n += out_tdata[0];
        rw_n   += out_tdata[1];
        if (verdict_q.size() == 0) begin
          bad_n++;
          if (bad_n <= PRINT_CAP)
            $display("%0t: verdict 0x%0h arrived with none outstanding", $time, out_tdata);
        end else begin
          want = verdict_q.pop_front();
          check_field("drop", want.drop, out_tdata[0]);
          check_field("rewrite_valid", want.rw_valid, out_tdata[1]);
          check_field("rewrite_offset", want.rw_ofs, out_tdata[17:2]);
          check_field("pad", 0, out_tdata[23:18]);
        end
      end
      if (in_tvalid && in_tready) take_byte(in_tdata, in_tlast);
    end
    mismatch_count <= bad_n;
    verdicts_owed  <= verdict_q.size();
    verdict_count  <= seen_n;
    drop_count     <= drop_n;
    rewrite_count  <= rw_n;
  end

endmodule

/* verif/tb.sv */
// Testbench top: drives packets and settings into the next-header locator and gives the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ipv6nhl_pkg::*;

  localparam int LIMIT_CYCLES   = 2_000_000;
  localparam int DRAIN_CYCLES   = 4;     // verdict is registered, valid in the cycle after tlast
  localparam int BACKLOG_CYCLES = 400;
  localparam int IDLE_PCT       = 35;

  // upper-layer protocol numbers used to end a chain
  localparam logic [7:0] NH_TCP   = 8'd6;
  localparam logic [7:0] NH_UDP   = 8'd17;
  localparam logic [7:0] NH_ICMP6 = 8'd58;
  localparam logic [7:0] NH_NONE  = 8'd59;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [7:0]               in_tdata   = '0;   // [7:0] pkt_byte
  logic                     in_tlast   = 1'b0; // last_byte
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [23:0]              out_tdata;         // [0] drop, [1] rewrite_valid, [17:2] offset
  logic                     cfg_wr_en  = 1'b0;
  logic                     cfg_index  = 1'b0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata  = '0;

  int mismatch_count, verdicts_owed, verdict_count, drop_count, rewrite_count;

  // pacing controls for the sender and the receiver
  bit tx_quiet, rx_quiet;
  int backlog_req, backlog_done;

  logic [7:0] pkt_buf[$];   // packet under construction
  int bytes_sent, pkts_sent, n_settings;

  ipv6_next_header_locator dut (.*);
  ipv6_next_header_locator_checker chk (.*);

  initial forever #6 clk = ~clk;

  // hard stop in case a handshake never completes
  initial begin
    #(LIMIT_CYCLES * 12);
    $display("timeout: %0d verdicts still outstanding", verdicts_owed);
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: random backpressure, a quiet stretch on request, and one long
  // hold-off so the verdict register fills and in_tready drops.
  initial begin : rx_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (backlog_req != backlog_done) begin
        backlog_done = backlog_req;
        hold_left    = BACKLOG_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (rx_quiet) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------- builders

  function automatic void add_bytes(input int n);
    repeat (n) pkt_buf.push_back(8'($urandom_range(255)));
  endfunction

  // 40-byte base header with the given next-header value at offset 6
  function automatic void begin_packet(input logic [7:0] nh);
    pkt_buf.delete();
    add_bytes(BASE_END);
    pkt_buf[BASE_NH_POS] = nh;
  endfunction

  // hop-by-hop / routing / destination: (len+1)*8 bytes
  function automatic void add_opt(input logic [7:0] nxt, input logic [7:0] lenf);
    pkt_buf.push_back(nxt);
    pkt_buf.push_back(lenf);
    add_bytes((int'(lenf) + 1) * 8 - 2);
  endfunction

  // auth header: (len+2)*4 bytes
  function automatic void add_auth(input logic [7:0] nxt, input logic [7:0] lenf);
    pkt_buf.push_back(nxt);
    pkt_buf.push_back(lenf);
    add_bytes((int'(lenf) + 2) * 4 - 2);
  endfunction

  // fragment header, 8 bytes; low three bits of the offset word are random flags
  function automatic void add_frag(input logic [7:0] nxt, input logic [12:0] fofs);
    pkt_buf.push_back(nxt);
    pkt_buf.push_back(8'($urandom_range(255)));
    pkt_buf.push_back(fofs[12:5]);
    pkt_buf.push_back({fofs[4:0], 3'($urandom_range(7))});
    add_bytes(4);
  endfunction

  function automatic void trim(input int n);
    while (pkt_buf.size() > n) void'(pkt_buf.pop_back());
  endfunction

  // mostly short headers, now and then one of any length up to 255
  function automatic logic [7:0] pick_len();
    return ($urandom_range(99) < 3) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
  endfunction

  // ---------------------------------------------------------------- drivers

  // One byte per transaction, tlast on the final byte. tvalid stays high
  // across back-to-back bytes and packets; random gaps drop it in between.
  task automatic send_packet();
    for (int i = 0; i < pkt_buf.size(); i++) begin
      while (!tx_quiet && $urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= pkt_buf[i];
      in_tlast  <= (i == pkt_buf.size() - 1);
      do @(posedge clk); while (!in_tready);
    end
    bytes_sent += pkt_buf.size();
    pkts_sent++;
  endtask

  // Stop sending and wait for every outstanding verdict, plus the register delay.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (verdicts_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register writes only while the block is idle.
  task automatic apply_settings(input logic [MODE_BITS-1:0] mf, input logic [7:0] np);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_MODE_FLAGS;
    cfg_wdata <= CFG_DATA_BITS'(mf);
    @(posedge clk);
    cfg_index <= REG_NEW_PROTOCOL;
    cfg_wdata <= np;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    int             phase_n, rand_pkts, rand_start, pick, n_ext;
    logic [7:0]     kinds[$];
    logic [7:0]     tail, k, nxt;
    logic [MODE_BITS-1:0] mf;
    logic [7:0]     np;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, register values as after reset (set protocol, no stops)

    // short base header: single byte, and ending just before offset 6
    pkt_buf.delete();
    pkt_buf.push_back(8'hFF);
    send_packet();
    begin_packet(NH_TCP); trim(6); send_packet();
    // next-header byte present, nothing more
    begin_packet(NH_TCP); trim(7); send_packet();
    begin_packet(NH_NONE); send_packet();
    begin_packet(8'hFF); add_bytes(8); send_packet();
    // plain chain through three option headers
    begin_packet(NH_HOP); add_opt(NH_ROUT, 8'd0); add_opt(NH_DEST, 8'd1);
    add_opt(NH_UDP, 8'd3); add_bytes(4); send_packet();
    // auth walked through, short and longer
    begin_packet(NH_AUTH); add_auth(NH_TCP, 8'd0); add_bytes(4); send_packet();
    begin_packet(NH_DEST); add_opt(NH_AUTH, 8'd0); add_auth(NH_ICMP6, 8'd5); send_packet();
    // first fragment is walked past
    begin_packet(NH_FRAG); add_frag(NH_TCP, 13'd0); add_bytes(8); send_packet();
    // later fragment that ends the chain, and later fragments whose chain goes on
    begin_packet(NH_FRAG); add_frag(NH_TCP, 13'h1FFF); send_packet();
    begin_packet(NH_FRAG); add_frag(NH_HOP, 13'd1); add_opt(NH_TCP, 8'd0); send_packet();
    begin_packet(NH_FRAG); add_frag(NH_AUTH, 13'd100); add_auth(NH_TCP, 8'd1); send_packet();
    // truncated chain: length byte missing, fragment offset missing, header missing
    begin_packet(NH_HOP); add_bytes(1); send_packet();
    begin_packet(NH_FRAG); add_bytes(3); send_packet();
    begin_packet(NH_HOP); send_packet();

    // --- stop at fragment and at auth
    apply_settings(3'd7, 8'hFF);
    begin_packet(NH_FRAG); add_frag(NH_TCP, 13'd0); send_packet();
    // fragment stop needs only its next-header and length bytes
    begin_packet(NH_HOP); add_opt(NH_FRAG, 8'd0); add_bytes(2); send_packet();
    begin_packet(NH_AUTH); add_auth(NH_TCP, 8'd0); send_packet();

    // --- stop at auth only: later fragment followed by auth ends there
    apply_settings(3'd5, 8'h00);
    begin_packet(NH_FRAG); add_frag(NH_AUTH, 13'd8); add_auth(NH_TCP, 8'd0); send_packet();
    begin_packet(NH_FRAG); add_frag(NH_NONE, 13'd3); send_packet();

    // --- rewrite disabled
    apply_settings(3'd0, 8'h5A);
    begin_packet(NH_TCP); send_packet();

    // --- random part, one register setting per group of packets
    phase_n    = 0;
    rand_pkts  = 0;
    rand_start = bytes_sent;
    do begin
      mf = (phase_n < 8) ? MODE_BITS'(7 - phase_n) : MODE_BITS'($urandom_range(7));
      np = (phase_n == 0) ? 8'hFF : (phase_n == 1) ? 8'h00 : 8'($urandom_range(255));
      apply_settings(mf, np);
      tx_quiet = (phase_n == 3);
      rx_quiet = (phase_n == 3);
      if (phase_n == 1) backlog_req++;   // long receiver hold-off in this group

      repeat ((phase_n == 1) ? 4 : 2) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          // well-formed chain with random content; part of them cut short
          kinds.delete();
          n_ext = $urandom_range(4);
          repeat (n_ext) begin
            case ($urandom_range(4))
              0:       k = NH_HOP;
              1:       k = NH_ROUT;
              2:       k = NH_FRAG;
              3:       k = NH_AUTH;
              default: k = NH_DEST;
            endcase
            kinds.push_back(k);
          end
          case ($urandom_range(7))
            0:       tail = NH_TCP;
            1:       tail = NH_UDP;
            2:       tail = NH_ICMP6;
            3:       tail = NH_NONE;
            4:       tail = 8'hFF;
            default: tail = 8'($urandom_range(255));
          endcase
          begin_packet((n_ext > 0) ? kinds[0] : tail);
          for (int i = 0; i < n_ext; i++) begin
            nxt = (i == n_ext - 1) ? tail : kinds[i + 1];
            case (kinds[i])
              NH_FRAG: add_frag(nxt, $urandom_range(1) ? 13'd0 : 13'($urandom_range(1, 8191)));
              NH_AUTH: add_auth(nxt, pick_len());
              default: add_opt(nxt, pick_len());
            endcase
          end
          add_bytes($urandom_range(24));
          if (pick >= 62) trim($urandom_range(1, pkt_buf.size()));
        end else begin
          // noise: short runs of arbitrary bytes
          pkt_buf.delete();
          add_bytes($urandom_range(1, 64));
        end
        send_packet();
        rand_pkts++;
      end
      phase_n++;
    end while (phase_n < 8 || rand_pkts < 16 || bytes_sent - rand_start < 800);

    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    settle();

    $display("run: %0d packets, %0d bytes, %0d register settings",
             pkts_sent, bytes_sent, n_settings);
    $display("verdicts: %0d total, %0d dropped, %0d with rewrite",
             verdict_count, drop_count, rewrite_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
